FILE: design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Immediate implication checked at every rising edge of clk unless dis is true.
`define ASSERT_IMPL(label, clk, dis, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked in the clock cycle after the antecedent.
`define ASSERT_NEXT(label, clk, dis, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/col_pkg.sv
package col_pkg;

    localparam int QUOT_BITS      = 8;
    localparam int STAGE_BITS     = 2;
    localparam int DIV_STAGES     = QUOT_BITS / STAGE_BITS;
    localparam int LEVEL_BITS     = 8;
    localparam int PAL_ENTRIES    = 16;
    localparam int PAL_IDX_BITS   = $clog2(PAL_ENTRIES);
    localparam int MAX_ITER_BITS  = 16;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;

    localparam logic [LEVEL_BITS-1:0] FULL_LEVEL = 8'd255;
    localparam logic [LEVEL_BITS-1:0] ZERO_LEVEL = 8'd0;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_BITS-1:0] CFG_THEME    = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_ITER = 2'd1;

    typedef enum logic [1:0] {
        THEME_RED_RAMP  = 2'd0,
        THEME_BLUE_RAMP = 2'd1,
        THEME_BLUE_RISE = 2'd2,
        THEME_PALETTE   = 2'd3
    } t_theme;

    localparam t_theme                   THEME_RESET    = THEME_PALETTE;
    localparam logic [MAX_ITER_BITS-1:0] MAX_ITER_RESET = 16'd256;

    // Per-pixel information that rides alongside the divider.
    typedef struct packed {
        logic                    blank;
        t_theme                  theme;
        logic [PAL_IDX_BITS-1:0] pal_idx;
    } t_side;

    localparam logic [LEVEL_BITS-1:0] PAL_RED [PAL_ENTRIES] = '{
        8'd66, 8'd25, 8'd9, 8'd4, 8'd0, 8'd12, 8'd24, 8'd57,
        8'd134, 8'd211, 8'd241, 8'd248, 8'd255, 8'd204, 8'd153, 8'd106
    };
    localparam logic [LEVEL_BITS-1:0] PAL_GREEN [PAL_ENTRIES] = '{
        8'd30, 8'd7, 8'd1, 8'd4, 8'd7, 8'd44, 8'd82, 8'd125,
        8'd181, 8'd236, 8'd233, 8'd201, 8'd170, 8'd128, 8'd87, 8'd52
    };
    localparam logic [LEVEL_BITS-1:0] PAL_BLUE [PAL_ENTRIES] = '{
        8'd15, 8'd26, 8'd47, 8'd73, 8'd100, 8'd138, 8'd177, 8'd209,
        8'd229, 8'd248, 8'd191, 8'd95, 8'd0, 8'd0, 8'd0, 8'd3
    };

endpackage

FILE: design/col_div_stage.sv
module col_div_stage
    import col_pkg::*;
#(
    parameter int COUNT_BITS = 16,
    parameter int TOP_BIT    = 7
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_adv,
    input  logic                             i_valid,
    input  logic [COUNT_BITS+LEVEL_BITS-1:0] i_rem,
    input  logic [QUOT_BITS-1:0]             i_quot,
    input  t_side                            i_side,
    input  logic [COUNT_BITS-1:0]            i_max,
    output logic                             o_valid,
    output logic [COUNT_BITS+LEVEL_BITS-1:0] o_rem,
    output logic [QUOT_BITS-1:0]             o_quot,
    output t_side                            o_side
);

    localparam int REM_BITS = COUNT_BITS + LEVEL_BITS;

    logic                 r_valid;
    logic [REM_BITS-1:0]  r_rem;
    logic [QUOT_BITS-1:0] r_quot;
    t_side                r_side;
    logic [REM_BITS-1:0]  n_rem;
    logic [QUOT_BITS-1:0] n_quot;
    logic [REM_BITS-1:0]  sub;

    // Two restoring steps: compare against the shifted divisor, subtract on a hit.
    always_comb begin
        n_rem  = i_rem;
        n_quot = i_quot;
        sub    = '0;
        for (int k = 0; k < STAGE_BITS; k++) begin
            sub = REM_BITS'(i_max) << (TOP_BIT - k);
            if (n_rem >= sub) begin
                n_rem  = n_rem - sub;
                n_quot = {n_quot[QUOT_BITS-2:0], 1'b1};
            end else begin
                n_quot = {n_quot[QUOT_BITS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_rem  <= n_rem;
            r_quot <= n_quot;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_quot  = r_quot;
    assign o_side  = r_side;

endmodule

FILE: design/col_shade.sv
module col_shade
    import col_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_stall,
    input  logic                  i_valid,
    input  logic [QUOT_BITS-1:0]  i_quot,
    input  logic                  i_rem_nz,
    input  t_side                 i_side,
    output logic                  o_adv,
    output logic                  o_valid,
    output logic [LEVEL_BITS-1:0] o_red_level,
    output logic [LEVEL_BITS-1:0] o_green_level,
    output logic [LEVEL_BITS-1:0] o_blue_level
);

    logic                  r_valid;
    logic [LEVEL_BITS-1:0] r_red;
    logic [LEVEL_BITS-1:0] r_green;
    logic [LEVEL_BITS-1:0] r_blue;
    logic [LEVEL_BITS-1:0] n_red;
    logic [LEVEL_BITS-1:0] n_green;
    logic [LEVEL_BITS-1:0] n_blue;
    logic [LEVEL_BITS:0]   ceil_q;
    logic [LEVEL_BITS-1:0] fall;

    assign o_adv = !r_valid || !i_stall;

    // The quotient is the floor; a nonzero remainder rounds it up for the falling ramp.
    assign ceil_q = {1'b0, i_quot} + (LEVEL_BITS + 1)'(i_rem_nz);
    assign fall   = LEVEL_BITS'({1'b0, FULL_LEVEL} - ceil_q);

    always_comb begin
        n_red   = ZERO_LEVEL;
        n_green = ZERO_LEVEL;
        n_blue  = ZERO_LEVEL;
        if (!i_side.blank) begin
            unique case (i_side.theme)
                THEME_RED_RAMP: begin
                    n_red   = FULL_LEVEL;
                    n_green = fall;
                    n_blue  = fall;
                end
                THEME_BLUE_RAMP: begin
                    n_red   = fall;
                    n_green = fall;
                    n_blue  = FULL_LEVEL;
                end
                THEME_BLUE_RISE: begin
                    n_blue = i_quot;
                end
                THEME_PALETTE: begin
                    n_red   = PAL_RED[i_side.pal_idx];
                    n_green = PAL_GREEN[i_side.pal_idx];
                    n_blue  = PAL_BLUE[i_side.pal_idx];
                end
                default: begin
                    n_red = ZERO_LEVEL;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            r_red   <= n_red;
            r_green <= n_green;
            r_blue  <= n_blue;
        end
    end

    assign o_valid       = r_valid;
    assign o_red_level   = r_red;
    assign o_green_level = r_green;
    assign o_blue_level  = r_blue;

endmodule

FILE: design/iteration_palette_colorizer.sv
// Escape-time pixel colorizer. Each input transfer carries the iteration count of
// one pixel and produces exactly one output transfer with that pixel's 8-bit red,
// green and blue levels, in input order. The block accepts one pixel every clock
// unless stalled, and each pixel passes through an entry register that forms 255 times
// the count, four divider stages that each resolve two of the eight quotient bits
// of 255*count/max_iterations, and an output register that maps the quotient to
// the selected theme. A stall from downstream holds the output register and backs
// up only as far as needed, so bubbles are squeezed out and no pixel is lost or
// repeated. Counts at or above max_iterations come out black. Configuration is
// taken on its own valid/ready port, which is always ready; theme_select and
// max_iterations should only be changed while no pixel is inside the pipeline.
module iteration_palette_colorizer
    import col_pkg::*;
#(
    parameter int COUNT_BITS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [COUNT_BITS-1:0]     i_iteration_count,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [LEVEL_BITS-1:0]     o_red_level,
    output logic [LEVEL_BITS-1:0]     o_green_level,
    output logic [LEVEL_BITS-1:0]     o_blue_level,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_data
);

    localparam int REM_BITS = COUNT_BITS + LEVEL_BITS;

    // Configuration registers.
    t_theme                   r_theme;
    logic [MAX_ITER_BITS-1:0] r_max_iter;
    logic [COUNT_BITS-1:0]    max_eff;

    // Entry stage.
    logic                r_e_valid;
    logic [REM_BITS-1:0] r_e_rem;
    t_side               r_e_side;
    logic [REM_BITS-1:0] n_e_rem;
    t_side               n_e_side;
    logic                e_adv;

    // Divider stage outputs and advance enables.
    logic                 div_valid [DIV_STAGES];
    logic [REM_BITS-1:0]  div_rem   [DIV_STAGES];
    logic [QUOT_BITS-1:0] div_quot  [DIV_STAGES];
    t_side                div_side  [DIV_STAGES];
    logic [DIV_STAGES-1:0] div_adv;
    logic                 out_adv;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_theme    <= THEME_RESET;
            r_max_iter <= MAX_ITER_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_THEME:    r_theme    <= t_theme'(i_cfg_data[1:0]);
                CFG_MAX_ITER: r_max_iter <= i_cfg_data;
                default:      r_max_iter <= r_max_iter;
            endcase
        end
    end

    // The limit is seen at the width of the count, the same as the count itself.
    assign max_eff = COUNT_BITS'(r_max_iter);

    // A stage moves when it is empty or when the stage after it moves. The stall
    // seen by the upstream side is the entry register being unable to move.
    assign e_adv   = !r_e_valid || div_adv[0];
    assign o_stall = !e_adv;

    generate
        for (genvar g = 0; g < DIV_STAGES - 1; g++) begin : g_adv
            assign div_adv[g] = !div_valid[g] || div_adv[g+1];
        end
    endgenerate
    assign div_adv[DIV_STAGES-1] = !div_valid[DIV_STAGES-1] || out_adv;

    // 255*c as a shift and a subtract. A count at or above the limit (including
    // a zero limit) is marked blank and its quotient is never used.
    always_comb begin
        n_e_rem = (REM_BITS'(i_iteration_count) << LEVEL_BITS)
                - REM_BITS'(i_iteration_count);
        n_e_side.blank   = !(i_iteration_count < max_eff);
        n_e_side.theme   = r_theme;
        n_e_side.pal_idx = i_iteration_count[PAL_IDX_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
        end else if (e_adv) begin
            r_e_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (e_adv) begin
            r_e_rem  <= n_e_rem;
            r_e_side <= n_e_side;
        end
    end

    // The quotient is below 255 because the count is below the limit, so eight
    // restoring steps starting at bit seven are enough.
    generate
        for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
            if (g == 0) begin : g_first
                col_div_stage #(
                    .COUNT_BITS (COUNT_BITS),
                    .TOP_BIT    (QUOT_BITS - 1)
                ) u_div_stage (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_adv   (div_adv[g]),
                    .i_valid (r_e_valid),
                    .i_rem   (r_e_rem),
                    .i_quot  ({QUOT_BITS{1'b0}}),
                    .i_side  (r_e_side),
                    .i_max   (max_eff),
                    .o_valid (div_valid[g]),
                    .o_rem   (div_rem[g]),
                    .o_quot  (div_quot[g]),
                    .o_side  (div_side[g])
                );
            end else begin : g_rest
                col_div_stage #(
                    .COUNT_BITS (COUNT_BITS),
                    .TOP_BIT    (QUOT_BITS - 1 - g * STAGE_BITS)
                ) u_div_stage (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_adv   (div_adv[g]),
                    .i_valid (div_valid[g-1]),
                    .i_rem   (div_rem[g-1]),
                    .i_quot  (div_quot[g-1]),
                    .i_side  (div_side[g-1]),
                    .i_max   (max_eff),
                    .o_valid (div_valid[g]),
                    .o_rem   (div_rem[g]),
                    .o_quot  (div_quot[g]),
                    .o_side  (div_side[g])
                );
            end
        end
    endgenerate

    // Output stage: theme mapping and the register that holds a stalled result.
    col_shade u_shade (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_stall       (i_stall),
        .i_valid       (div_valid[DIV_STAGES-1]),
        .i_quot        (div_quot[DIV_STAGES-1]),
        .i_rem_nz      (|div_rem[DIV_STAGES-1]),
        .i_side        (div_side[DIV_STAGES-1]),
        .o_adv         (out_adv),
        .o_valid       (o_valid),
        .o_red_level   (o_red_level),
        .o_green_level (o_green_level),
        .o_blue_level  (o_blue_level)
    );

endmodule

FILE: design/col_check.sv
`include "assert_macros.svh"

module col_check
    import col_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_stall,
    input logic                  o_stall,
    input logic                  o_valid,
    input logic [LEVEL_BITS-1:0] o_red_level,
    input logic [LEVEL_BITS-1:0] o_green_level,
    input logic [LEVEL_BITS-1:0] o_blue_level
);

    // A result held back by downstream stays put with its colors.
    `ASSERT_NEXT(a_hold_result, i_clk, !i_rst_n, o_valid && i_stall, o_valid && $stable(o_red_level) && $stable(o_green_level) && $stable(o_blue_level), "stalled result changed")

    // With room at the output every stage can move, so the input is never stalled.
    `ASSERT_IMPL(a_no_needless_stall, i_clk, !i_rst_n, !o_valid || !i_stall, !o_stall, "input stalled while output can move")

    // Reset empties the pipeline, output register included.
    `ASSERT_IMPL(a_reset_empties, i_clk, 1'b0, $past(!i_rst_n), !o_valid, "result present right after reset")

endmodule

bind iteration_palette_colorizer col_check u_col_check (.*);
